// ----- sv/krr_pkg.sv -----
// shared constants and codes for the keyframe replay ring
package krr_pkg;

   localparam int SLOT_W   = 6;
   localparam int HANDLE_W = 16;
   localparam int KIND_W   = 2;

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_REPLAY = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ADDED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NOKEY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

endpackage

// ----- sv/krr_ram.sv -----
// generic single write port ram with registered read
module krr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/krr_step.sv -----
// shared ring pointer step unit with wrap and end compare
module krr_step #(
   parameter int DEPTH = 64
) (
   input  logic [$clog2(DEPTH)-1:0] pos,
   input  logic                     down,
   input  logic [$clog2(DEPTH)-1:0] end_pos,
   output logic [$clog2(DEPTH)-1:0] next_pos,
   output logic                     at_end
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);

   always_comb begin
      if (down) begin
         next_pos = (pos == '0) ? LAST_POS : pos - PTR_W'(1);
      end else begin
         next_pos = (pos == LAST_POS) ? '0 : pos + PTR_W'(1);
      end
      at_end = (next_pos == end_pos);
   end

endmodule

// ----- sv/keyframe_replay_ring.sv -----
// packet handle ring with replay from the newest keyframe
//
// channel   ports                                   handshake
// request   req_func req_packet_handle req_key_frame  start, taken when busy low
//           req_end_slot
// response  rsp_kind rsp_slot rsp_out_handle rsp_last rsp_strobe, one cycle each
//
// an add is handled in idle and its response shows in the next cycle
// a replay searches backward one slot at a time (at most DEPTH slots),
// then a walk and an emit state per replayed entry via the handle ram read port
// reset clears write pointer, valid and key flags at once, no clearing pass
// responses cannot be stalled, busy holds off requests during a replay
module keyframe_replay_ring #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [krr_pkg::HANDLE_W-1:0]   req_packet_handle,
   input  logic                           req_key_frame,
   input  logic [krr_pkg::SLOT_W-1:0]     req_end_slot,
   output logic                           rsp_strobe,
   output logic [krr_pkg::KIND_W-1:0]     rsp_kind,
   output logic [krr_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [krr_pkg::HANDLE_W-1:0]   rsp_out_handle,
   output logic                           rsp_last
);

   import krr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic [PTR_W-1:0] end_ff, end_in;
   logic [PTR_W-1:0] slot_ff, slot_in;
   logic             last_ff, last_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [DEPTH-1:0] key_ff, key_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [PTR_W-1:0]    step_pos;
   logic                step_down;
   logic [PTR_W-1:0]    step_next;
   logic                step_at_end;
   logic                ram_we;
   logic [HANDLE_W-1:0] ram_rdata;
   logic [PTR_W-1:0]    end_sat;
   logic                hit;

   krr_step #(.DEPTH(DEPTH)) u_step (
      .pos      (step_pos),
      .down     (step_down),
      .end_pos  (end_ff),
      .next_pos (step_next),
      .at_end   (step_at_end)
   );

   krr_ram #(.WIDTH(HANDLE_W), .DEPTH(DEPTH)) u_handle_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (step_next),
      .wr_data (req_packet_handle),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign busy = (state_ff != ST_IDLE);
   assign hit  = valid_ff[pos_ff] & key_ff[pos_ff];
   assign end_sat = (32'(req_end_slot) >= DEPTH) ? PTR_W'(DEPTH - 1)
                                                 : req_end_slot[PTR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      pos_in        = pos_ff;
      end_in        = end_ff;
      slot_in       = slot_ff;
      last_in       = last_ff;
      valid_in      = valid_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_last_in   = rsp_last_ff;
      step_pos      = pos_ff;
      step_down     = 1'b0;
      ram_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            step_pos = wp_ff;
            if (start) begin
               if (req_func == FUNC_ADD) begin
                  ram_we              = 1'b1;
                  valid_in[step_next] = 1'b1;
                  key_in[step_next]   = req_key_frame;
                  wp_in               = step_next;
                  rsp_strobe_in       = 1'b1;
                  rsp_kind_in         = KIND_ADDED;
                  rsp_slot_in         = SLOT_W'(step_next);
                  rsp_handle_in       = '0;
                  rsp_last_in         = 1'b1;
               end else begin
                  end_in   = end_sat;
                  pos_in   = end_sat;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            step_down = 1'b1;
            if (hit) begin
               if (pos_ff == '0 && end_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_kind_in   = KIND_EMPTY;
                  rsp_slot_in   = '0;
                  rsp_handle_in = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_WALK;
               end
            end else if (step_at_end) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_NOKEY;
               rsp_slot_in   = '0;
               rsp_handle_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               pos_in = step_next;
            end
         end
         ST_WALK: begin
            slot_in  = pos_ff;
            last_in  = step_at_end | ~valid_ff[step_next];
            pos_in   = step_next;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_ENTRY;
            rsp_slot_in   = SLOT_W'(slot_ff);
            rsp_handle_in = ram_rdata;
            rsp_last_in   = last_ff;
            state_in      = last_ff ? ST_IDLE : ST_WALK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         valid_ff      <= '0;
         key_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         valid_ff      <= valid_in;
         key_ff        <= key_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      end_ff        <= end_in;
      slot_ff       <= slot_in;
      last_ff       <= last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_last       = rsp_last_ff;

   a_add_responds: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_ADD)
      |=> (rsp_strobe && rsp_kind == KIND_ADDED && rsp_last))
      else $error("add transaction without added response");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind != KIND_ENTRY) |-> (rsp_last && rsp_out_handle == '0))
      else $error("non entry response not final or carries a handle");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("final response while still busy");

   a_emit_after_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> $past(state_ff == ST_WALK))
      else $error("emit without a preceding ram read");

   a_walk_on_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> valid_ff[pos_ff])
      else $error("replay walk on an empty slot");

endmodule
